// File: sv/spol_pkg.sv
// Shared types, constants and codes for the sprite packet ordering-table linker.
// Used by every module of the block except spol_ram; depends on nothing.
package spol_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [31:0] IDENTITY_SCALE  = 32'h1000_1000;
    localparam logic [31:0] DRAW_MODE_BASE  = 32'hE100_0200;
    localparam logic [31:0] COLOR_CODE_BASE = 32'h6400_0000;
    localparam logic [7:0]  LINK_LEN        = 8'd5;
    localparam logic [23:0] PACKET_BYTES    = 24'd24;
    localparam logic [2:0]  WORD_LAST       = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_TABLE_HEAD  = 3'd0;
    localparam logic [2:0] CFG_TABLE_LEN   = 3'd1;
    localparam logic [2:0] CFG_OFFSET_X    = 3'd2;
    localparam logic [2:0] CFG_OFFSET_Y    = 3'd3;
    localparam logic [2:0] CFG_PACKET_BASE = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_WRITTEN   = 3'd0;
    localparam logic [2:0] ST_HIDDEN    = 3'd1;
    localparam logic [2:0] ST_ZERO_W    = 3'd2;
    localparam logic [2:0] ST_ZERO_H    = 3'd3;
    localparam logic [2:0] ST_TRANSFORM = 3'd4;

    typedef struct packed {
        logic [31:0]        sprite_attr;
        logic [31:0]        pos_xy;
        logic [31:0]        size_wh;
        logic [15:0]        tex_uv;
        logic [4:0]         tex_page;
        logic [31:0]        clut_xy;
        logic [23:0]        color_rgb;
        logic [31:0]        handle_xy;
        logic [31:0]        scale_xy;
        logic signed [31:0] rotation;
        logic [7:0]         priority_req;
    } t_sprite;

    typedef struct packed {
        logic [31:0] packet_word;
        logic [2:0]  word_index;
        logic [23:0] packet_addr;
        logic [31:0] slot_addr;
        logic [2:0]  status;
        logic        depth_underflow;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [23:0]        table_head;
        logic [7:0]         table_len;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
    } t_cfg;

    // Classified sprite: payload words 1..5 (words[0] holds word 1)
    typedef struct packed {
        logic [7:0]       prio;
        logic [31:0]      slot_addr;
        logic             under;
        logic [2:0]       status;
        logic [4:0][31:0] words;
    } t_job;

endpackage

// File: sv/spol_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spol_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: sv/spol_front.sv
// Front end: classifies an incoming sprite and builds payload words 1..5.
// Depends on spol_pkg.
module spol_front (
    input  spol_pkg::t_cfg    i_cfg,
    input  spol_pkg::t_sprite i_sprite,
    output spol_pkg::t_job    o_job
);
    import spol_pkg::*;

    logic        fast;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
    logic [2:0]  status;

    always_comb begin
        fast = i_sprite.sprite_attr[27] ||
               (i_sprite.scale_xy == IDENTITY_SCALE && i_sprite.rotation == 32'sd0 &&
                i_sprite.sprite_attr[23:22] == 2'b00);
        if (i_sprite.sprite_attr[31]) begin
            status = ST_HIDDEN;
        end else if (i_sprite.size_wh[15:0] == 16'd0) begin
            status = ST_ZERO_W;
        end else if (i_sprite.size_wh[31:16] == 16'd0) begin
            status = ST_ZERO_H;
        end else if (!fast) begin
            status = ST_TRANSFORM;
        end else begin
            status = ST_WRITTEN;
        end

        // Both sums wrap to 16 bits
        x = i_sprite.pos_xy[15:0] + i_cfg.offset_x - i_sprite.handle_xy[15:0];
        y = i_sprite.pos_xy[31:16] + i_cfg.offset_y - i_sprite.handle_xy[31:16];

        w1 = DRAW_MODE_BASE | {27'd0, i_sprite.tex_page}
           | {23'd0, i_sprite.sprite_attr[25:24], 7'd0}
           | {25'd0, i_sprite.sprite_attr[29:28], 5'd0};
        w2 = COLOR_CODE_BASE | {6'd0, i_sprite.sprite_attr[30], i_sprite.sprite_attr[6], 24'd0}
           | {8'd0, i_sprite.color_rgb};
        w3 = {y, x};
        w4 = {i_sprite.clut_xy[25:16], 6'd0, i_sprite.tex_uv}
           | {10'd0, i_sprite.clut_xy[9:4], 16'd0};

        o_job.prio      = i_sprite.priority_req;
        o_job.slot_addr = {8'd0, i_cfg.table_head} + {22'd0, i_sprite.priority_req, 2'b00}
                        - {22'd0, i_cfg.table_len, 2'b00};
        o_job.under     = i_sprite.priority_req < i_cfg.table_len;
        o_job.status    = status;
        o_job.words     = {i_sprite.size_wh, w4, w3, w2, w1};
    end
endmodule

// File: sv/spol_fifo.sv
// Short job queue between the front end and the packet emitter.
// Depends on spol_pkg.
module spol_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spol_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output spol_pkg::t_job o_job
);
    import spol_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end
endmodule

// File: sv/spol_back.sv
// Back end: emits packet words, links packets into the ordering table and
// runs the allocator. Depends on spol_pkg and spol_ram.
module spol_back #(
    parameter int TABLE_DEPTH = spol_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_alloc_load,
    input  logic [23:0]       i_alloc_data,
    input  logic              i_job_valid,
    input  spol_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spol_pkg::t_result o_out_data
);
    import spol_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_idx;
    logic          r_cur_valid;
    t_job          r_cur;
    logic [2:0]    r_widx;
    logic [23:0]   r_alloc;
    logic          r_out_valid;
    t_result       r_out;

    t_result       n_out;
    logic          emit;
    logic          is_fast;
    logic          finish;
    logic          in_range;
    logic          pop;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [23:0]   ram_rdata;
    logic [23:0]   old_entry;

    assign is_fast  = r_cur.status == ST_WRITTEN;
    assign emit     = r_cur_valid && (!r_out_valid || !i_out_stall);
    assign finish   = emit && (!is_fast || r_widx == WORD_LAST);
    assign pop      = i_job_valid && !r_clr_busy && (!r_cur_valid || finish);
    assign in_range = 32'(r_cur.prio) < TABLE_DEPTH;
    assign old_entry = in_range ? ram_rdata : 24'd0;

    // Link on the first word of a written packet; the clearing pass owns the port after reset
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = 24'd0;
        end else begin
            ram_we    = emit && is_fast && r_widx == 3'd0 && in_range;
            ram_waddr = AW'(r_cur.prio);
            ram_wdata = r_alloc;
        end
    end

    spol_ram #(
        .WIDTH(24),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (pop),
        .i_rd_addr (AW'(i_job.prio)),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        n_out.packet_addr     = r_alloc;
        n_out.slot_addr       = r_cur.slot_addr;
        n_out.status          = r_cur.status;
        n_out.depth_underflow = r_cur.under;
        if (is_fast) begin
            n_out.word_index = r_widx;
            n_out.last       = r_widx == WORD_LAST;
            case (r_widx)
                3'd0:    n_out.packet_word = {LINK_LEN, old_entry};
                3'd1:    n_out.packet_word = r_cur.words[0];
                3'd2:    n_out.packet_word = r_cur.words[1];
                3'd3:    n_out.packet_word = r_cur.words[2];
                3'd4:    n_out.packet_word = r_cur.words[3];
                3'd5:    n_out.packet_word = r_cur.words[4];
                default: n_out.packet_word = 32'd0;
            endcase
        end else begin
            n_out.word_index  = 3'd0;
            n_out.last        = 1'b1;
            n_out.packet_word = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_cur_valid <= 1'b0;
            r_widx      <= 3'd0;
            r_alloc     <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(TABLE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_alloc_load) begin
                r_alloc <= i_alloc_data;
            end else if (finish && is_fast) begin
                r_alloc <= r_alloc + PACKET_BYTES;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                r_cur_valid <= 1'b1;
                r_widx      <= 3'd0;
            end else if (finish) begin
                r_cur_valid <= 1'b0;
            end else if (emit) begin
                r_widx <= r_widx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_job;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_pop       = pop;
    assign o_clearing  = r_clr_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_WRITTEN |-> r_out.last && r_out.word_index == 3'd0)
        else $error("status-only result not a single last item");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_widx <= WORD_LAST)
        else $error("word index past end of packet");

    a_no_work_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_cur_valid && !r_out_valid)
        else $error("work in flight during table clearing");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish && is_fast && !i_alloc_load |=> r_alloc == $past(r_alloc) + PACKET_BYTES)
        else $error("allocator did not advance after written packet");
endmodule

// File: sv/sprite_packet_ot_linker_core.sv
// A written sprite gives six packet words on the result channel, one per cycle while
// i_out_stall is low; a rejected or transform sprite gives a single status-only result.
// Path: a sprite is queued, loaded into the current-job register, and each result is registered.
// Reset: synchronous, active low; clears the control registers, then sweeps the ordering
// table to zero at one entry per cycle with o_in_stall high.
// Depends on spol_pkg, spol_front, spol_fifo, spol_back, spol_ram.
module sprite_packet_ot_linker_core #(
    parameter int TABLE_DEPTH = spol_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [23:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spol_pkg::t_sprite i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spol_pkg::t_result o_out_data
);
    import spol_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job q_job;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;
    logic accept;
    logic alloc_load;

    assign o_in_stall = q_full || clearing;
    assign accept     = i_in_valid && !o_in_stall;
    assign alloc_load = i_cfg_we && i_cfg_idx == CFG_PACKET_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_HEAD: r_cfg.table_head <= i_cfg_data;
                CFG_TABLE_LEN:  r_cfg.table_len  <= i_cfg_data[7:0];
                CFG_OFFSET_X:   r_cfg.offset_x   <= i_cfg_data[15:0];
                CFG_OFFSET_Y:   r_cfg.offset_y   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    spol_front u_front (
        .i_cfg    (r_cfg),
        .i_sprite (i_in_data),
        .o_job    (front_job)
    );

    spol_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    spol_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_alloc_load (alloc_load),
        .i_alloc_data (i_cfg_data),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );
endmodule
